@@ rtl/irfp_pkg.sv @@
// Shared types and constants for the IMU RVC frame parser.
package irfp_pkg;

  localparam int unsigned FrameBytes = 19;
  localparam int unsigned PosW       = 5;
  localparam int unsigned StoreFirst = 2;
  localparam int unsigned StoreLast  = 14;

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosHunt1 = PosW'(0);
  localparam pos_t PosHunt2 = PosW'(1);
  localparam pos_t PosSeq   = PosW'(StoreFirst);
  localparam pos_t PosLast  = PosW'(FrameBytes - 1);

  localparam logic [7:0] HeaderByte = 8'hAA;

  localparam logic StatusOk          = 1'b0;
  localparam logic StatusChecksumErr = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               frame_status;
    logic [7:0]         sequence_number;
    logic signed [15:0] yaw_centideg;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] accel_x_milli_g;
    logic signed [15:0] accel_y_milli_g;
    logic signed [15:0] accel_z_milli_g;
    logic [31:0]        good_frame_count;
    logic [31:0]        bad_frame_count;
  } result_t;

endpackage

@@ rtl/irfp_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
interface irfp_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/imu_rvc_frame_parser.sv @@
// The last byte's transaction registers the result into the output stage, or the skid stage if occupied.
// Throughput: one byte per cycle while ready is high; position counter and running checksum update per byte.
// Input ready drops only while both the output register and the skid stage hold results.
// Reset (rst_ni low, asynchronous) returns to header hunt and clears both frame counters.
// Frame payload bytes are held in plain registers and need no reset.
module imu_rvc_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  irfp_stream_if.sink   rx_i,
  irfp_stream_if.source res_o
);

  logic              accept;
  logic              done;
  logic              full;
  irfp_pkg::result_t result;

  assign rx_i.ready = !full;
  assign accept     = rx_i.valid && rx_i.ready;

  irfp_assembler u_assembler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.payload.rx_byte),
    .done_o    (done),
    .result_o  (result)
  );

  irfp_out_buffer u_out_buffer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (done),
    .data_i (result),
    .full_o (full),
    .res_o  (res_o)
  );

endmodule

@@ rtl/irfp_assembler.sv @@
// Header hunt, byte position tracking, running checksum and frame counters.
module irfp_assembler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              done_o,
  output irfp_pkg::result_t result_o
);

  irfp_pkg::pos_t pos_q, pos_d;
  logic [7:0]     sum_q, sum_d;
  logic [31:0]    good_q, good_d;
  logic [31:0]    bad_q, bad_d;
  logic [7:0]     store_q [irfp_pkg::StoreFirst:irfp_pkg::StoreLast];
  logic           sum_ok;

  assign sum_ok = (sum_q == rx_byte_i);

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    good_d = good_q;
    bad_d  = bad_q;
    done_o = 1'b0;
    if (accept_i) begin
      case (pos_q)
        irfp_pkg::PosHunt1: begin
          if (rx_byte_i == irfp_pkg::HeaderByte) pos_d = irfp_pkg::PosHunt2;
        end
        irfp_pkg::PosHunt2: begin
          // a bad second header byte is dropped, not rechecked
          pos_d = (rx_byte_i == irfp_pkg::HeaderByte) ? irfp_pkg::PosSeq
                                                      : irfp_pkg::PosHunt1;
        end
        irfp_pkg::PosLast: begin
          pos_d  = irfp_pkg::PosHunt1;
          done_o = 1'b1;
          if (sum_ok) good_d = good_q + 32'd1;
          else        bad_d  = bad_q + 32'd1;
        end
        default: begin
          if (pos_q > irfp_pkg::PosLast) begin
            pos_d = irfp_pkg::PosHunt1;
          end else begin
            pos_d = pos_q + irfp_pkg::PosW'(1);
            sum_d = (pos_q == irfp_pkg::PosSeq) ? rx_byte_i : sum_q + rx_byte_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= irfp_pkg::PosHunt1;
      good_q <= '0;
      bad_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      good_q <= good_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    for (int i = irfp_pkg::StoreFirst; i <= irfp_pkg::StoreLast; i++) begin
      if (accept_i && pos_q == irfp_pkg::PosW'(i)) store_q[i] <= rx_byte_i;
    end
  end

  always_comb begin
    result_o                  = '0;
    result_o.good_frame_count = good_d;
    result_o.bad_frame_count  = bad_d;
    if (sum_ok) begin
      result_o.frame_status    = irfp_pkg::StatusOk;
      result_o.sequence_number = store_q[2];
      result_o.yaw_centideg    = {store_q[4], store_q[3]};
      result_o.pitch_centideg  = {store_q[6], store_q[5]};
      result_o.roll_centideg   = {store_q[8], store_q[7]};
      result_o.accel_x_milli_g = {store_q[10], store_q[9]};
      result_o.accel_y_milli_g = {store_q[12], store_q[11]};
      result_o.accel_z_milli_g = {store_q[14], store_q[13]};
    end else begin
      result_o.frame_status = irfp_pkg::StatusChecksumErr;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= irfp_pkg::PosLast)
    else $error("byte position out of range");

  a_done_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> pos_q == irfp_pkg::PosHunt1)
    else $error("parser not hunting after a completed frame");

  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (good_q + bad_q) == ($past(good_q) + $past(bad_q) + 32'd1))
    else $error("a completed frame did not bump exactly one counter");

endmodule

@@ rtl/irfp_out_buffer.sv @@
// Output register with a skid stage so input keeps flowing while a result waits.
module irfp_out_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  irfp_pkg::result_t data_i,
  output logic              full_o,
  irfp_stream_if.source     res_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  irfp_pkg::result_t out_q, out_d;
  irfp_pkg::result_t skid_q, skid_d;
  logic              take;

  assign take = out_valid_q && res_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        // advance the parked result
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o        = skid_valid_q;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output stage is empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed while skid stage is full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> out_valid_q && !skid_valid_q)
    else $error("parked result lost on drain");

endmodule
